// ----- rtl/core/sbd_pkg.sv -----
// Shared types, constants and helpers for the switch bank debouncer.
// No dependencies; used by sbd_lane, sbd_merge and switch_bank_debouncer_unit.
package sbd_pkg;

    localparam int LANE_CAP         = 8;
    localparam int SWITCH_COUNT_DEF = 8;
    localparam int FIELD_W          = 8;
    localparam int SEL_W            = 3;
    localparam int REQ_W            = 2;
    localparam int WINDOW_W         = 4;
    localparam int CFG_INDEX_W      = 1;
    localparam int CFG_DATA_W       = 8;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 4'd3;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 2'd0,
        REQ_POLL  = 2'd1,
        REQ_QUERY = 2'd2
    } req_type_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WINDOW = 1'b0,
        CFG_ENABLE = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic tick;
        logic poll;
        logic clear;
        logic stop;
    } lane_ctrl_t;

    typedef struct packed {
        logic sampling;
        logic level;
        logic changed;
    } lane_status_t;

    typedef struct packed {
        logic               sel_ready;
        logic               sel_level;
        logic               sel_changed;
        logic [FIELD_W-1:0] level_mask;
        logic [FIELD_W-1:0] sampling_mask;
        logic               tick_active;
    } result_t;

    function automatic logic [FIELD_W-1:0] settle_bits(input logic [WINDOW_W-1:0] len);
        logic [FIELD_W-1:0] mask;
        begin
            unique case (len)
                4'd0, 4'd1: mask = 8'h01;
                4'd2:       mask = 8'h03;
                4'd3:       mask = 8'h07;
                4'd4:       mask = 8'h0f;
                4'd5:       mask = 8'h1f;
                4'd6:       mask = 8'h3f;
                4'd7:       mask = 8'h7f;
                default:    mask = 8'hff;
            endcase
            return mask;
        end
    endfunction

endpackage

// ----- rtl/core/sbd_lane.sv -----
// One debounce lane: sample history, settled level, changed flag, sampling bit.
// Depends on sbd_pkg.
module sbd_lane
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  sbd_pkg::lane_ctrl_t                 ctrl,
    input  logic                                pin,
    input  logic [sbd_pkg::FIELD_W-1:0]         wmask,
    output sbd_pkg::lane_status_t               status_next
);

    logic [sbd_pkg::FIELD_W-1:0] history_reg;
    logic [sbd_pkg::FIELD_W-1:0] history_next;
    logic                        level_reg;
    logic                        level_next;
    logic                        changed_reg;
    logic                        changed_next;
    logic                        sampling_reg;
    logic                        sampling_next;
    logic [sbd_pkg::FIELD_W-1:0] shifted;

    assign shifted = {history_reg[sbd_pkg::FIELD_W-2:0], ~pin};

    always_comb
    begin
        history_next  = history_reg;
        level_next    = level_reg;
        changed_next  = changed_reg;
        sampling_next = sampling_reg;
        if (ctrl.clear)
        begin
            level_next    = 1'b0;
            changed_next  = 1'b0;
            sampling_next = 1'b0;
        end
        else if (ctrl.stop)
        begin
            sampling_next = 1'b0;
        end
        else if (ctrl.tick && sampling_reg)
        begin
            history_next = shifted;
            if ((shifted & wmask) == wmask)
            begin
                changed_next  = ~level_reg;
                level_next    = 1'b1;
                sampling_next = 1'b0;
            end
            else if ((shifted & wmask) == '0)
            begin
                changed_next  = level_reg;
                level_next    = 1'b0;
                sampling_next = 1'b0;
            end
        end
        else if (ctrl.poll)
        begin
            sampling_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg  <= '0;
            level_reg    <= 1'b0;
            changed_reg  <= 1'b0;
            sampling_reg <= 1'b0;
        end
        else
        begin
            history_reg  <= history_next;
            level_reg    <= level_next;
            changed_reg  <= changed_next;
            sampling_reg <= sampling_next;
        end
    end

    assign status_next.sampling = sampling_next;
    assign status_next.level    = level_next;
    assign status_next.changed  = changed_next;

endmodule

// ----- rtl/core/sbd_merge.sv -----
// Merges lane status into one result item and holds it in a two-entry output queue.
// Depends on sbd_pkg.
module sbd_merge
#(
    parameter int LANE_COUNT = sbd_pkg::LANE_CAP
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic [sbd_pkg::SEL_W-1:0]         sel,
    input  sbd_pkg::lane_status_t             lane_status [LANE_COUNT],
    output logic                              full,
    output logic                              out_valid,
    input  logic                              out_stall,
    output sbd_pkg::result_t                  head
);

    localparam int DEPTH = 2;

    sbd_pkg::result_t            result;
    sbd_pkg::result_t            slot_reg [DEPTH];
    logic                        wr_ptr_reg;
    logic                        wr_ptr_next;
    logic                        rd_ptr_reg;
    logic                        rd_ptr_next;
    logic [1:0]                  count_reg;
    logic [1:0]                  count_next;
    logic                        pop;
    logic [sbd_pkg::FIELD_W-1:0] lmask;
    logic [sbd_pkg::FIELD_W-1:0] smask;

    always_comb
    begin
        lmask              = '0;
        smask              = '0;
        result.sel_ready   = 1'b1;
        result.sel_level   = 1'b0;
        result.sel_changed = 1'b0;
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            lmask[i] = lane_status[i].level;
            smask[i] = lane_status[i].sampling;
            if (sel == sbd_pkg::SEL_W'(i))
            begin
                result.sel_ready   = ~lane_status[i].sampling;
                result.sel_level   = lane_status[i].level;
                result.sel_changed = lane_status[i].changed;
            end
        end
        result.level_mask    = lmask;
        result.sampling_mask = smask;
        result.tick_active   = |smask;
    end

    assign full      = (count_reg == 2'(DEPTH));
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && !out_stall;
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(DEPTH))
        else $error("output queue count overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("item pushed into a full output queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (head.tick_active == (head.sampling_mask != '0)))
        else $error("tick_active disagrees with sampling_mask");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("output queue lost an item");

endmodule

// ----- rtl/core/switch_bank_debouncer_unit.sv -----
// Top level of the switch bank debouncer: input decode, config registers, lanes, merge.
// Depends on sbd_pkg, sbd_lane and sbd_merge.
//
//   port group   direction  handshake           payload
//   in           to block   in_valid/in_stall   req_type, switch_index, pin_levels
//   out          from block out_valid/out_stall sel_*, level_mask, sampling_mask, tick_active
//   cfg          to block   cfg_we              cfg_index, cfg_data
//
// One item per cycle while not stalled; each result is registered into the output queue.
// All lanes update in the accept cycle; the two-entry output queue sets the stall.
// in_stall rises only when two results wait unread.
// rst_n clears history, levels, flags, sampling bits and the queue at once.
module switch_bank_debouncer_unit
#(
    parameter int SWITCH_COUNT = sbd_pkg::SWITCH_COUNT_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [sbd_pkg::REQ_W-1:0]          req_type,
    input  logic [sbd_pkg::SEL_W-1:0]          switch_index,
    input  logic [sbd_pkg::FIELD_W-1:0]        pin_levels,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               sel_ready,
    output logic                               sel_level,
    output logic                               sel_changed,
    output logic [sbd_pkg::FIELD_W-1:0]        level_mask,
    output logic [sbd_pkg::FIELD_W-1:0]        sampling_mask,
    output logic                               tick_active,
    input  logic                               cfg_we,
    input  logic [sbd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sbd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int LANE_COUNT = (SWITCH_COUNT < sbd_pkg::LANE_CAP) ?
                                SWITCH_COUNT : sbd_pkg::LANE_CAP;

    logic [sbd_pkg::WINDOW_W-1:0] window_reg;
    logic [sbd_pkg::WINDOW_W-1:0] window_next;
    logic [LANE_COUNT-1:0]        enabled_reg;
    logic [LANE_COUNT-1:0]        enabled_next;
    logic [sbd_pkg::FIELD_W-1:0]  wmask;
    logic                         accept;
    logic                         tick;
    logic                         poll;
    logic                         enable_wr;
    sbd_pkg::lane_ctrl_t          lane_ctrl [LANE_COUNT];
    sbd_pkg::lane_status_t        lane_status [LANE_COUNT];
    sbd_pkg::result_t             head;

    assign accept    = in_valid && !in_stall;
    assign tick      = accept && (req_type == sbd_pkg::REQ_TICK);
    assign poll      = accept && (req_type == sbd_pkg::REQ_POLL);
    assign enable_wr = cfg_we && (cfg_index == sbd_pkg::CFG_ENABLE);
    assign wmask     = sbd_pkg::settle_bits(window_reg);

    always_comb
    begin
        window_next  = window_reg;
        enabled_next = enabled_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                sbd_pkg::CFG_WINDOW: window_next  = cfg_data[sbd_pkg::WINDOW_W-1:0];
                sbd_pkg::CFG_ENABLE: enabled_next = cfg_data[LANE_COUNT-1:0];
                default:             window_next  = window_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= sbd_pkg::WINDOW_RESET;
            enabled_reg <= '0;
        end
        else
        begin
            window_reg  <= window_next;
            enabled_reg <= enabled_next;
        end
    end

    for (genvar i = 0; i < LANE_COUNT; i++)
    begin : g_lane
        assign lane_ctrl[i].tick  = tick;
        assign lane_ctrl[i].poll  = poll && enabled_reg[i] &&
                                    (switch_index == sbd_pkg::SEL_W'(i));
        assign lane_ctrl[i].clear = enable_wr && !enabled_reg[i] && cfg_data[i];
        assign lane_ctrl[i].stop  = enable_wr && enabled_reg[i] && !cfg_data[i];

        sbd_lane u_lane
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (lane_ctrl[i]),
            .pin         (pin_levels[i]),
            .wmask       (wmask),
            .status_next (lane_status[i])
        );
    end

    sbd_merge
    #(
        .LANE_COUNT (LANE_COUNT)
    )
    u_merge
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (accept),
        .sel         (switch_index),
        .lane_status (lane_status),
        .full        (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .head        (head)
    );

    assign sel_ready     = head.sel_ready;
    assign sel_level     = head.sel_level;
    assign sel_changed   = head.sel_changed;
    assign level_mask    = head.level_mask;
    assign sampling_mask = head.sampling_mask;
    assign tick_active   = head.tick_active;

endmodule

// ----- sim/tb_switch_bank_debouncer_unit.sv -----
// Self-checking bench for switch_bank_debouncer_unit: directed and random tick/poll/query items
// against a bit-accurate bank predictor, with random sender gaps and receiver stalls.
// Depends on sbd_pkg and the switch_bank_debouncer_unit RTL.
module tb_switch_bank_debouncer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sbd_pkg::*;

    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
    localparam int IDLE_LIMIT = 1000;
    localparam int MAX_SHOWN = 10;

    typedef struct {
        logic [REQ_W-1:0]   req;
        logic [SEL_W-1:0]   idx;
        logic [FIELD_W-1:0] pins;
    } switch_item_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [REQ_W-1:0]       req_type = REQ_QUERY;
    logic [SEL_W-1:0]       switch_index = '0;
    logic [FIELD_W-1:0]     pin_levels = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   sel_ready;
    logic                   sel_level;
    logic                   sel_changed;
    logic [FIELD_W-1:0]     level_mask;
    logic [FIELD_W-1:0]     sampling_mask;
    logic                   tick_active;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_WINDOW;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // bank predictor state
    logic [FIELD_W-1:0]  lane_history [LANE_CAP];
    logic [LANE_CAP-1:0] lane_level = '0;
    logic [LANE_CAP-1:0] lane_changed = '0;
    logic [LANE_CAP-1:0] lane_sampling = '0;
    logic [WINDOW_W-1:0] window_len = WINDOW_RESET;
    logic [LANE_CAP-1:0] enable_bits = '0;

    switch_item_t switch_requests [$];
    result_t      expected_status [$];
    switch_item_t current_item;
    int           items_queued = 0;
    int           items_accepted = 0;
    int           error_count = 0;
    int           burst_left = 1;
    int           gap_left = 0;
    bit           wait_for_drain = 0;
    int           stall_mode = 0;
    int           mode_cycles = 0;
    int           stall_run = 0;
    bit           stall_state = 0;
    int           idle_cycles = 0;

    switch_bank_debouncer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .switch_index (switch_index),
        .pin_levels   (pin_levels),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sel_ready    (sel_ready),
        .sel_level    (sel_level),
        .sel_changed  (sel_changed),
        .level_mask   (level_mask),
        .sampling_mask(sampling_mask),
        .tick_active  (tick_active),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        for (int i = 0; i < LANE_CAP; i++)
        begin
            lane_history[i] = '0;
        end
    end

    function automatic result_t predict_bank_response(switch_item_t it);
        result_t            res;
        logic [FIELD_W-1:0] wbits;
        logic [FIELD_W-1:0] hist;
        int                 w;
        int                 i;
        w = int'(window_len);
        if (w < 1)
            w = 1;
        if (w > LANE_CAP)
            w = LANE_CAP;
        wbits = FIELD_W'((1 << w) - 1);
        if (it.req == REQ_TICK)
        begin
            for (i = 0; i < LANE_CAP; i++)
            begin
                if (lane_sampling[i])
                begin
                    hist = {lane_history[i][FIELD_W-2:0], ~it.pins[i]};
                    lane_history[i] = hist;
                    if ((hist & wbits) == wbits)
                    begin
                        lane_changed[i] = ~lane_level[i];
                        lane_level[i] = 1'b1;
                        lane_sampling[i] = 1'b0;
                    end
                    else if ((hist & wbits) == '0)
                    begin
                        lane_changed[i] = lane_level[i];
                        lane_level[i] = 1'b0;
                        lane_sampling[i] = 1'b0;
                    end
                end
            end
        end
        else if (it.req == REQ_POLL)
        begin
            if (enable_bits[it.idx])
                lane_sampling[it.idx] = 1'b1;
        end
        res.sel_ready = ~lane_sampling[it.idx];
        res.sel_level = lane_level[it.idx];
        res.sel_changed = lane_changed[it.idx];
        res.level_mask = lane_level;
        res.sampling_mask = lane_sampling;
        res.tick_active = |lane_sampling;
        return res;
    endfunction

    function automatic void queue_item(logic [REQ_W-1:0] req, logic [SEL_W-1:0] idx,
                                       logic [FIELD_W-1:0] pins);
        switch_item_t it;
        it.req = req;
        it.idx = idx;
        it.pins = pins;
        switch_requests.push_back(it);
        items_queued++;
    endfunction

    task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        int i;
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == CFG_WINDOW)
        begin
            window_len = value[WINDOW_W-1:0];
        end
        else
        begin
            for (i = 0; i < LANE_CAP; i++)
            begin
                if (!enable_bits[i] && value[i])
                begin
                    lane_level[i] = 1'b0;
                    lane_changed[i] = 1'b0;
                    lane_sampling[i] = 1'b0;
                end
                else if (enable_bits[i] && !value[i])
                begin
                    lane_sampling[i] = 1'b0;
                end
            end
            enable_bits = value[LANE_CAP-1:0];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic settle_bank();
        while (switch_requests.size() != 0 || in_valid || expected_status.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic queue_random_phase(int count);
        int                 first;
        int                 polls;
        int                 ticks;
        int                 bounce;
        int                 queries;
        int                 j;
        logic [SEL_W-1:0]   idx;
        logic [FIELD_W-1:0] pressed;
        logic [FIELD_W-1:0] noise;
        first = items_queued;
        while (items_queued - first < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                queue_item(REQ_W'($urandom_range(3)), SEL_W'($urandom_range(7)),
                           FIELD_W'($urandom_range(255)));
            end
            else
            begin
                polls = $urandom_range(4, 1);
                for (j = 0; j < polls; j++)
                begin
                    idx = SEL_W'($urandom_range(7));
                    if (enable_bits != '0 && $urandom_range(4) != 0)
                    begin
                        while (!enable_bits[idx])
                            idx = SEL_W'($urandom_range(7));
                    end
                    queue_item(REQ_POLL, idx, FIELD_W'($urandom_range(255)));
                end
                pressed = FIELD_W'($urandom_range(255));
                ticks = $urandom_range(12, 1);
                bounce = $urandom_range(ticks - 1, 0);
                for (j = 0; j < ticks; j++)
                begin
                    noise = (j < bounce) ? FIELD_W'($urandom_range(255) & $urandom_range(255))
                                         : '0;
                    queue_item(REQ_TICK, SEL_W'($urandom_range(7)), ~pressed ^ noise);
                    if ($urandom_range(7) == 0)
                        queue_item(REQ_QUERY, SEL_W'($urandom_range(7)),
                                   FIELD_W'($urandom_range(255)));
                end
                queries = $urandom_range(2);
                for (j = 0; j < queries; j++)
                    queue_item(REQ_QUERY, SEL_W'($urandom_range(7)),
                               FIELD_W'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        int               k;
        logic [WINDOW_W-1:0] win;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: nothing enabled, window of three
        queue_item(REQ_POLL, 3'd0, 8'hFF);
        queue_item(REQ_TICK, 3'd0, 8'h00);
        queue_item(REQ_QUERY, 3'd7, 8'h00);
        queue_item(REQ_SPARE, 3'd5, 8'hFF);
        settle_bank();

        write_register(CFG_WINDOW, 8'h01);
        write_register(CFG_ENABLE, 8'hFF);
        @(negedge clk);
        queue_item(REQ_POLL, 3'd0, 8'h00);
        queue_item(REQ_POLL, 3'd0, 8'h00);
        queue_item(REQ_POLL, 3'd7, 8'h00);
        queue_item(REQ_TICK, 3'd0, 8'h7E);
        queue_item(REQ_QUERY, 3'd7, 8'h00);
        queue_item(REQ_POLL, 3'd3, 8'h00);
        queue_item(REQ_TICK, 3'd3, 8'hFF);
        queue_item(REQ_POLL, 3'd0, 8'h00);
        queue_item(REQ_TICK, 3'd0, 8'hFF);
        settle_bank();

        // window above eight, upper switches unbound
        write_register(CFG_WINDOW, 8'hFF);
        write_register(CFG_ENABLE, 8'h0F);
        @(negedge clk);
        queue_item(REQ_POLL, 3'd1, 8'h00);
        queue_item(REQ_TICK, 3'd1, 8'hFF);
        queue_item(REQ_POLL, 3'd2, 8'h00);
        queue_item(REQ_TICK, 3'd2, 8'h00);
        queue_item(REQ_TICK, 3'd2, 8'hFB);
        queue_item(REQ_QUERY, 3'd7, 8'h00);
        queue_item(REQ_POLL, 3'd7, 8'h00);
        settle_bank();

        // window of zero, rebind the upper switches
        write_register(CFG_WINDOW, 8'hA0);
        write_register(CFG_ENABLE, 8'hF0);
        @(negedge clk);
        queue_item(REQ_QUERY, 3'd2, 8'h00);
        queue_item(REQ_QUERY, 3'd7, 8'h00);
        queue_item(REQ_POLL, 3'd5, 8'h00);
        queue_item(REQ_TICK, 3'd5, 8'h00);
        queue_item(REQ_SPARE, 3'd5, 8'h00);
        settle_bank();

        for (k = 0; k < 10; k++)
        begin
            case (k)
                0:       win = 4'd1;
                1:       win = 4'd8;
                2:       win = 4'd0;
                3:       win = 4'd15;
                default: win = WINDOW_W'($urandom_range(7, 2));
            endcase
            if ($urandom_range(2) == 0)
                write_register(CFG_ENABLE, 8'h00);
            write_register(CFG_WINDOW, {4'($urandom_range(15)), win});
            write_register(CFG_ENABLE, (k == 0) ? 8'hFF : CFG_DATA_W'($urandom_range(255, 1)));
            @(negedge clk);
            queue_random_phase(150);
            settle_bank();
        end

        repeat (8) @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_status.push_back(predict_bank_response(current_item));
                items_accepted++;
                if (items_accepted % 400 == 200 || $urandom_range(199) == 0)
                    wait_for_drain = 1;
            end
            if (!(in_valid && in_stall))
            begin
                if (wait_for_drain && expected_status.size() == 0)
                    wait_for_drain = 0;
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (wait_for_drain || switch_requests.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    current_item = switch_requests.pop_front();
                    in_valid <= 1'b1;
                    req_type <= current_item.req;
                    switch_index <= current_item.idx;
                    pin_levels <= current_item.pins;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(40, 1);
                        gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 1);
                    end
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_res;
        result_t got;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.sel_ready = sel_ready;
                got.sel_level = sel_level;
                got.sel_changed = sel_changed;
                got.level_mask = level_mask;
                got.sampling_mask = sampling_mask;
                got.tick_active = tick_active;
                if (expected_status.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_SHOWN)
                        $display("%0t: result with no item outstanding", $realtime);
                end
                else
                begin
                    exp_res = expected_status.pop_front();
                    if (got !== exp_res)
                    begin
                        error_count++;
                        if (error_count <= MAX_SHOWN)
                        begin
                            $display("%0t: mismatch exp/got ready %b/%b level %b/%b changed %b/%b",
                                     $realtime, exp_res.sel_ready, got.sel_ready,
                                     exp_res.sel_level, got.sel_level,
                                     exp_res.sel_changed, got.sel_changed);
                            $display("    levels %h/%h sampling %h/%h active %b/%b",
                                     exp_res.level_mask, got.level_mask,
                                     exp_res.sampling_mask, got.sampling_mask,
                                     exp_res.tick_active, got.tick_active);
                        end
                    end
                end
            end
            if (mode_cycles == 0)
            begin
                stall_mode = $urandom_range(3);
                mode_cycles = $urandom_range(200, 20);
            end
            mode_cycles--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(3) == 0);
                2: out_stall <= $urandom_range(1);
                default:
                begin
                    if (stall_run == 0)
                    begin
                        stall_state = ~stall_state;
                        stall_run = $urandom_range(12, 1);
                    end
                    stall_run--;
                    out_stall <= stall_state;
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
rtl/core/sbd_pkg.sv
rtl/core/sbd_lane.sv
rtl/core/sbd_merge.sv
rtl/core/switch_bank_debouncer_unit.sv
sim/tb_switch_bank_debouncer_unit.sv
